[hdl/bze_pkg.sv]
package bze_pkg;

    localparam int FRAC_BITS    = 16;
    localparam int NEWTON_STEPS = 4;

    // port widths
    localparam int W_T = 17;
    localparam int W_Y = 19;

    // guess u: signed, holds the +/-4.0 clamp and an unclamped start guess
    localparam int W_U = ((FRAC_BITS + 3 > W_T + 1) ? FRAC_BITS + 3 : W_T + 1) + 1;
    // curve coefficients
    localparam int W_K = (FRAC_BITS + 3 > 24) ? FRAC_BITS + 3 : 24;

    // Horner chain of the curve
    localparam int WP1 = W_K + W_U - FRAC_BITS;
    localparam int WQ1 = WP1 + 1;
    localparam int WP2 = WQ1 + W_U - FRAC_BITS;
    localparam int WQ2 = WP2 + 1;
    localparam int WX  = WQ2 + W_U - FRAC_BITS;

    // slope terms
    localparam int WM3 = W_K + 2 + W_U - FRAC_BITS;
    localparam int WS1 = WM3 + W_U - FRAC_BITS;
    localparam int WM2 = W_K + 1 + W_U - FRAC_BITS;
    localparam int WS  = WS1 + 2;

    // Newton division
    localparam int WE = WX + 1;
    localparam int WN = WE + FRAC_BITS;
    localparam int QB = W_U;
    localparam int WD = WS + QB - 1;
    localparam int WR = (WN > WD) ? WN : WD;
    localparam int WC = (WN > WS + QB) ? WN : WS + QB;
    localparam int WF = QB + 3;

    localparam int ONE     = 1 << FRAC_BITS;
    localparam int ULIM    = 1 << (FRAC_BITS + 2);
    localparam int OUT_MIN = -131072;
    localparam int OUT_MAX = 196608;

    typedef enum logic [1:0] {
        CFG_X1 = 2'd0,
        CFG_Y1 = 2'd1,
        CFG_X2 = 2'd2,
        CFG_Y2 = 2'd3
    } t_cfg_idx;

    typedef struct packed {
        logic [W_T-1:0]        t;
        logic signed [W_U-1:0] u;
        logic                  stop;
    } t_ctx;

    typedef struct packed {
        logic signed [W_K-1:0] a;
        logic signed [W_K-1:0] b;
        logic signed [W_K-1:0] c;
        logic signed [W_K+1:0] a3;
        logic signed [W_K:0]   b2;
    } t_coef;

    typedef struct packed {
        t_ctx           ctx;
        logic [WR-1:0]  rem;
        logic [WR-1:0]  dsh;
        logic [QB-1:0]  quo;
        logic           neg;
        logic           ovf;
    } t_div;

endpackage

[hdl/bze_div_cell.sv]
// One restoring division step: one quotient bit per cell.
module bze_div_cell (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_valid,
    input  bze_pkg::t_div i_div,
    output logic          o_valid,
    output bze_pkg::t_div o_div
);

    logic          r_valid;
    bze_pkg::t_div r_div;
    bze_pkg::t_div n_div;
    logic          ge;

    always_comb begin
        ge        = (i_div.rem >= i_div.dsh);
        n_div     = i_div;
        n_div.rem = ge ? (i_div.rem - i_div.dsh) : i_div.rem;
        n_div.quo = {i_div.quo[bze_pkg::QB-2:0], ge};
        n_div.dsh = i_div.dsh >> 1;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_div <= n_div;
    end

    assign o_valid = r_valid;
    assign o_div   = r_div;

endmodule

[hdl/bze_newton_cell.sv]
// One Newton step: evaluate x(u) and slope, divide, update and clamp u; u is kept once the slope is zero.
module bze_newton_cell (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  bze_pkg::t_coef i_coef,
    input  logic           i_valid,
    input  bze_pkg::t_ctx  i_ctx,
    output logic           o_valid,
    output bze_pkg::t_ctx  o_ctx
);

    localparam int F = bze_pkg::FRAC_BITS;

    // stage A: first products
    logic signed [bze_pkg::W_K+bze_pkg::W_U-1:0]   pa;
    logic signed [bze_pkg::W_K+2+bze_pkg::W_U-1:0] pm3;
    logic signed [bze_pkg::W_K+1+bze_pkg::W_U-1:0] pm2;
    logic                          r_a_valid;
    bze_pkg::t_ctx                 r_a_ctx;
    logic signed [bze_pkg::WP1-1:0] r_a_p1;
    logic signed [bze_pkg::WM3-1:0] r_a_m3;
    logic signed [bze_pkg::WM2-1:0] r_a_m2;

    assign pa  = i_coef.a * i_ctx.u;
    assign pm3 = i_coef.a3 * i_ctx.u;
    assign pm2 = i_coef.b2 * i_ctx.u;

    always_ff @(posedge i_clk) begin
        r_a_ctx <= i_ctx;
        r_a_p1  <= bze_pkg::WP1'(pa >>> F);
        r_a_m3  <= bze_pkg::WM3'(pm3 >>> F);
        r_a_m2  <= bze_pkg::WM2'(pm2 >>> F);
    end

    // stage B: second Horner product and slope
    logic signed [bze_pkg::WQ1-1:0]             q1;
    logic signed [bze_pkg::WQ1+bze_pkg::W_U-1:0] pb;
    logic signed [bze_pkg::WM3+bze_pkg::W_U-1:0] pms;
    logic signed [bze_pkg::WS-1:0]              sl;
    logic                           r_b_valid;
    bze_pkg::t_ctx                  r_b_ctx;
    logic signed [bze_pkg::WP2-1:0] r_b_p2;
    logic signed [bze_pkg::WS-1:0]  r_b_sl;

    assign q1  = bze_pkg::WQ1'(r_a_p1) + bze_pkg::WQ1'(i_coef.b);
    assign pb  = q1 * r_a_ctx.u;
    assign pms = r_a_m3 * r_a_ctx.u;
    assign sl  = bze_pkg::WS'(bze_pkg::WS1'(pms >>> F)) + bze_pkg::WS'(r_a_m2)
               + bze_pkg::WS'(i_coef.c);

    always_ff @(posedge i_clk) begin
        r_b_ctx <= r_a_ctx;
        r_b_p2  <= bze_pkg::WP2'(pb >>> F);
        r_b_sl  <= sl;
    end

    // stage C: x(u) - t
    logic signed [bze_pkg::WQ2-1:0]             q2;
    logic signed [bze_pkg::WQ2+bze_pkg::W_U-1:0] pc;
    logic signed [bze_pkg::WX-1:0]              xv;
    logic                          r_c_valid;
    bze_pkg::t_ctx                 r_c_ctx;
    logic signed [bze_pkg::WE-1:0] r_c_err;
    logic signed [bze_pkg::WS-1:0] r_c_sl;

    assign q2 = bze_pkg::WQ2'(r_b_p2) + bze_pkg::WQ2'(i_coef.c);
    assign pc = q2 * r_b_ctx.u;
    assign xv = bze_pkg::WX'(pc >>> F);

    always_ff @(posedge i_clk) begin
        r_c_ctx <= r_b_ctx;
        r_c_sl  <= r_b_sl;
        r_c_err <= bze_pkg::WE'(xv) - bze_pkg::WE'($signed({1'b0, r_b_ctx.t}));
    end

    // stage D: divider setup, magnitudes and overflow check
    logic signed [bze_pkg::WN-1:0] num;
    logic [bze_pkg::WN-1:0]        nmag;
    logic [bze_pkg::WS-1:0]        smag;
    bze_pkg::t_div                 n_d_div;
    bze_pkg::t_div                 r_d_div;
    logic                          r_d_valid;

    always_comb begin
        num          = {r_c_err, {F{1'b0}}};
        nmag         = num[bze_pkg::WN-1] ? bze_pkg::WN'(-num) : bze_pkg::WN'(num);
        smag         = r_c_sl[bze_pkg::WS-1] ? bze_pkg::WS'(-r_c_sl) : bze_pkg::WS'(r_c_sl);
        n_d_div.ctx  = r_c_ctx;
        n_d_div.ctx.stop = r_c_ctx.stop | (r_c_sl == '0);
        n_d_div.rem  = bze_pkg::WR'(nmag);
        n_d_div.dsh  = bze_pkg::WR'(bze_pkg::WD'(smag) << (bze_pkg::QB - 1));
        n_d_div.quo  = '0;
        n_d_div.neg  = num[bze_pkg::WN-1] ^ r_c_sl[bze_pkg::WS-1];
        n_d_div.ovf  = bze_pkg::WC'(nmag) >= (bze_pkg::WC'(smag) << bze_pkg::QB);
    end

    always_ff @(posedge i_clk) begin
        r_d_div <= n_d_div;
    end

    // divider chain
    logic          w_val [0:bze_pkg::QB];
    bze_pkg::t_div w_div [0:bze_pkg::QB];

    assign w_val[0] = r_d_valid;
    assign w_div[0] = r_d_div;

    for (genvar k = 0; k < bze_pkg::QB; k++) begin : g_div
        bze_div_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_valid (w_val[k]),
            .i_div   (w_div[k]),
            .o_valid (w_val[k+1]),
            .o_div   (w_div[k+1])
        );
    end

    // stage U: apply the step and clamp the guess
    bze_pkg::t_div                 dq;
    logic [bze_pkg::QB:0]          qmag;
    logic signed [bze_pkg::QB+1:0] qs;
    logic signed [bze_pkg::WF-1:0] diff;
    bze_pkg::t_ctx                 n_u_ctx;
    bze_pkg::t_ctx                 r_u_ctx;
    logic                          r_u_valid;

    always_comb begin
        dq      = w_div[bze_pkg::QB];
        qmag    = dq.ovf ? (bze_pkg::QB+1)'(1) << bze_pkg::QB : {1'b0, dq.quo};
        qs      = dq.neg ? -$signed({1'b0, qmag}) : $signed({1'b0, qmag});
        diff    = bze_pkg::WF'(dq.ctx.u) - bze_pkg::WF'(qs);
        n_u_ctx = dq.ctx;
        if (!dq.ctx.stop) begin
            if (diff > bze_pkg::WF'(bze_pkg::ULIM)) begin
                n_u_ctx.u = bze_pkg::W_U'(bze_pkg::ULIM);
            end else if (diff < bze_pkg::WF'(-bze_pkg::ULIM)) begin
                n_u_ctx.u = bze_pkg::W_U'(-bze_pkg::ULIM);
            end else begin
                n_u_ctx.u = bze_pkg::W_U'(diff);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_u_ctx <= n_u_ctx;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_valid <= 1'b0;
            r_b_valid <= 1'b0;
            r_c_valid <= 1'b0;
            r_d_valid <= 1'b0;
            r_u_valid <= 1'b0;
        end else begin
            r_a_valid <= i_valid;
            r_b_valid <= r_a_valid;
            r_c_valid <= r_b_valid;
            r_d_valid <= r_c_valid;
            r_u_valid <= w_val[bze_pkg::QB];
        end
    end

    assign o_valid = r_u_valid;
    assign o_ctx   = r_u_ctx;

endmodule

[hdl/cubic_bezier_easing_unit.sv]
// Cubic Bezier easing unit.
// Throughput one beat per cycle; busy is never raised, every cycle may start a beat.
// Each Newton step is a row of 25 register stages: 4 for curve, slope and divider
// setup, 20 one-bit divider cells, 1 for the guess update; the y curve takes 3 more
// and the output register 1.
// Synchronous active-low reset clears the pipeline valid flags and loads the default
// control points (0,0) and (1,1). Results leave on o_valid for one cycle; no stall.
module cubic_bezier_easing_unit (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              start,
    output logic                              busy,
    input  logic [bze_pkg::W_T-1:0]           i_progress,
    output logic                              o_valid,
    output logic signed [bze_pkg::W_Y-1:0]    o_eased,
    input  logic                              i_cfg_we,
    input  logic [1:0]                        i_cfg_idx,
    input  logic [bze_pkg::W_Y-1:0]           i_cfg_data
);

    localparam int F = bze_pkg::FRAC_BITS;

    // control point registers
    logic [bze_pkg::W_T-1:0]        r_x1;
    logic [bze_pkg::W_T-1:0]        r_x2;
    logic signed [bze_pkg::W_Y-1:0] r_y1;
    logic signed [bze_pkg::W_Y-1:0] r_y2;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_x1 <= '0;
            r_y1 <= '0;
            r_x2 <= bze_pkg::W_T'(bze_pkg::ONE);
            r_y2 <= bze_pkg::W_Y'(bze_pkg::ONE);
        end else if (i_cfg_we) begin
            unique case (bze_pkg::t_cfg_idx'(i_cfg_idx))
                bze_pkg::CFG_X1: r_x1 <= i_cfg_data[bze_pkg::W_T-1:0];
                bze_pkg::CFG_Y1: r_y1 <= i_cfg_data;
                bze_pkg::CFG_X2: r_x2 <= i_cfg_data[bze_pkg::W_T-1:0];
                bze_pkg::CFG_Y2: r_y2 <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // Coefficients follow the control points in the next cycle; the user must change config
    // only while the pipe is empty, so no beat sees a half update; the block does not enforce it.
    logic signed [bze_pkg::W_K-1:0] kx1, kx2, ky1, ky2;
    bze_pkg::t_coef n_cx, n_cy, r_cx, r_cy;
    logic           r_lin;

    always_comb begin
        kx1 = bze_pkg::W_K'($signed({1'b0, r_x1}));
        kx2 = bze_pkg::W_K'($signed({1'b0, r_x2}));
        ky1 = bze_pkg::W_K'(r_y1);
        ky2 = bze_pkg::W_K'(r_y2);

        n_cx.a  = bze_pkg::W_K'(bze_pkg::ONE) - bze_pkg::W_K'(kx2 * 3) + bze_pkg::W_K'(kx1 * 3);
        n_cx.b  = bze_pkg::W_K'(kx2 * 3) - bze_pkg::W_K'(kx1 * 6);
        n_cx.c  = bze_pkg::W_K'(kx1 * 3);
        n_cx.a3 = (bze_pkg::W_K+2)'(n_cx.a) * 3;
        n_cx.b2 = (bze_pkg::W_K+1)'(n_cx.b) <<< 1;

        n_cy.a  = bze_pkg::W_K'(bze_pkg::ONE) - bze_pkg::W_K'(ky2 * 3) + bze_pkg::W_K'(ky1 * 3);
        n_cy.b  = bze_pkg::W_K'(ky2 * 3) - bze_pkg::W_K'(ky1 * 6);
        n_cy.c  = bze_pkg::W_K'(ky1 * 3);
        n_cy.a3 = (bze_pkg::W_K+2)'(n_cy.a) * 3;
        n_cy.b2 = (bze_pkg::W_K+1)'(n_cy.b) <<< 1;
    end

    always_ff @(posedge i_clk) begin
        r_cx  <= n_cx;
        r_cy  <= n_cy;
        // straight-line curve: hand the progress back untouched
        r_lin <= (r_y1 == $signed({2'b00, r_x1})) && (r_y2 == $signed({2'b00, r_x2}));
    end

    // the pipe never stalls
    assign busy = 1'b0;

    // input stage: start guess u = t
    logic          r_in_valid;
    bze_pkg::t_ctx r_in_ctx;

    always_ff @(posedge i_clk) begin
        r_in_ctx.t    <= i_progress;
        r_in_ctx.u    <= bze_pkg::W_U'($signed({1'b0, i_progress}));
        r_in_ctx.stop <= 1'b0;
    end

    // chain of Newton steps
    logic          w_val [0:bze_pkg::NEWTON_STEPS];
    bze_pkg::t_ctx w_ctx [0:bze_pkg::NEWTON_STEPS];

    assign w_val[0] = r_in_valid;
    assign w_ctx[0] = r_in_ctx;

    for (genvar s = 0; s < bze_pkg::NEWTON_STEPS; s++) begin : g_step
        bze_newton_cell u_step (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_coef  (r_cx),
            .i_valid (w_val[s]),
            .i_ctx   (w_ctx[s]),
            .o_valid (w_val[s+1]),
            .o_ctx   (w_ctx[s+1])
        );
    end

    // y(u) in Horner form, three products
    bze_pkg::t_ctx yc;
    logic signed [bze_pkg::W_K+bze_pkg::W_U-1:0] py1;
    logic signed [bze_pkg::WQ1-1:0]             yq1;
    logic signed [bze_pkg::WQ1+bze_pkg::W_U-1:0] py2;
    logic signed [bze_pkg::WQ2-1:0]             yq2;
    logic signed [bze_pkg::WQ2+bze_pkg::W_U-1:0] py3;

    logic                           r_y1_valid, r_y2_valid, r_y3_valid, r_o_valid;
    bze_pkg::t_ctx                  r_y1_ctx, r_y2_ctx;
    logic [bze_pkg::W_T-1:0]        r_y3_t;
    logic signed [bze_pkg::WP1-1:0] r_y1_p;
    logic signed [bze_pkg::WP2-1:0] r_y2_p;
    logic signed [bze_pkg::WX-1:0]  r_y3_y;
    logic signed [bze_pkg::W_Y-1:0] r_o_eased;

    assign yc  = w_ctx[bze_pkg::NEWTON_STEPS];
    assign py1 = r_cy.a * yc.u;
    assign yq1 = bze_pkg::WQ1'(r_y1_p) + bze_pkg::WQ1'(r_cy.b);
    assign py2 = yq1 * r_y1_ctx.u;
    assign yq2 = bze_pkg::WQ2'(r_y2_p) + bze_pkg::WQ2'(r_cy.c);
    assign py3 = yq2 * r_y2_ctx.u;

    always_ff @(posedge i_clk) begin
        r_y1_ctx <= yc;
        r_y1_p   <= bze_pkg::WP1'(py1 >>> F);
        r_y2_ctx <= r_y1_ctx;
        r_y2_p   <= bze_pkg::WP2'(py2 >>> F);
        r_y3_t   <= r_y2_ctx.t;
        r_y3_y   <= bze_pkg::WX'(py3 >>> F);
        // pick the bypass or saturate y to the output range
        if (r_lin) begin
            r_o_eased <= $signed({2'b00, r_y3_t});
        end else if (r_y3_y > bze_pkg::WX'(bze_pkg::OUT_MAX)) begin
            r_o_eased <= bze_pkg::W_Y'(bze_pkg::OUT_MAX);
        end else if (r_y3_y < bze_pkg::WX'(bze_pkg::OUT_MIN)) begin
            r_o_eased <= bze_pkg::W_Y'(bze_pkg::OUT_MIN);
        end else begin
            r_o_eased <= bze_pkg::W_Y'(r_y3_y);
        end
    end

    // valid flags: advance one stage per cycle
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
            r_y1_valid <= 1'b0;
            r_y2_valid <= 1'b0;
            r_y3_valid <= 1'b0;
            r_o_valid  <= 1'b0;
        end else begin
            r_in_valid <= start & ~busy;
            r_y1_valid <= w_val[bze_pkg::NEWTON_STEPS];
            r_y2_valid <= r_y1_valid;
            r_y3_valid <= r_y2_valid;
            r_o_valid  <= r_y3_valid;
        end
    end

    assign o_valid = r_o_valid;
    assign o_eased = r_o_eased;

endmodule

[test/testbench.sv]
`timescale 1ns / 1ps

module testbench;

    // Reference of the easing curve plus the queue of eased values still to come.
    class easing_scoreboard;
        logic [bze_pkg::W_T-1:0]        x1, x2;
        logic signed [bze_pkg::W_Y-1:0] y1, y2;
        logic signed [bze_pkg::W_Y-1:0] eased_q[$];
        int                             errors;

        function new();
            errors = 0;
            load_defaults();
        endfunction

        function void load_defaults();
            x1 = '0;
            y1 = '0;
            x2 = bze_pkg::W_T'(bze_pkg::ONE);
            y2 = bze_pkg::W_Y'(bze_pkg::ONE);
        endfunction

        // x regs keep their low 17 bits only
        function void write_reg(bze_pkg::t_cfg_idx idx, logic [bze_pkg::W_Y-1:0] data);
            case (idx)
                bze_pkg::CFG_X1: x1 = data[bze_pkg::W_T-1:0];
                bze_pkg::CFG_Y1: y1 = data;
                bze_pkg::CFG_X2: x2 = data[bze_pkg::W_T-1:0];
                bze_pkg::CFG_Y2: y2 = data;
                default: ;
            endcase
        endfunction

        // floor of a product scaled back to Q16
        function longint flr(longint v);
            return v >>> bze_pkg::FRAC_BITS;
        endfunction

        function longint horner(longint u, longint a, longint b, longint c);
            return flr((flr((flr(a * u) + b) * u) + c) * u);
        endfunction

        function longint deriv(longint u, longint a, longint b, longint c);
            return flr(flr(3 * a * u) * u) + flr(2 * b * u) + c;
        endfunction

        function logic signed [bze_pkg::W_Y-1:0] ease(logic [bze_pkg::W_T-1:0] prog);
            longint t, px1, px2, py1, py2, ax, bx, cx, ay, by, cy, u, y, s, err;
            t   = longint'(prog);
            px1 = longint'(x1);
            px2 = longint'(x2);
            py1 = longint'(y1);
            py2 = longint'(y2);
            if (px1 == py1 && px2 == py2) begin
                y = t;
            end else begin
                ax = bze_pkg::ONE - 3 * px2 + 3 * px1;
                bx = 3 * px2 - 6 * px1;
                cx = 3 * px1;
                ay = bze_pkg::ONE - 3 * py2 + 3 * py1;
                by = 3 * py2 - 6 * py1;
                cy = 3 * py1;
                u  = t;
                for (int k = 0; k < bze_pkg::NEWTON_STEPS; k++) begin
                    s = deriv(u, ax, bx, cx);
                    // flat spot: keep the current guess
                    if (s == 0) break;
                    err = horner(u, ax, bx, cx) - t;
                    u   = u - (err * bze_pkg::ONE) / s;
                    if (u > bze_pkg::ULIM)  u = bze_pkg::ULIM;
                    if (u < -bze_pkg::ULIM) u = -bze_pkg::ULIM;
                end
                y = horner(u, ay, by, cy);
            end
            if (y > bze_pkg::OUT_MAX) y = bze_pkg::OUT_MAX;
            if (y < bze_pkg::OUT_MIN) y = bze_pkg::OUT_MIN;
            return bze_pkg::W_Y'(y);
        endfunction

        function void note_beat(logic [bze_pkg::W_T-1:0] prog);
            eased_q.insert(eased_q.size(), ease(prog));
        endfunction

        function void check_beat(logic signed [bze_pkg::W_Y-1:0] got);
            logic signed [bze_pkg::W_Y-1:0] want;
            if (eased_q.size() == 0) begin
                $error("eased: unexpected result %0d", got);
                errors++;
                return;
            end
            want = eased_q[0];
            eased_q.delete(0);
            if (got !== want) begin
                $error("eased: expected %0d, actual %0d", want, got);
                errors++;
            end
        endfunction
    endclass

    localparam int LATENCY = 1 + bze_pkg::NEWTON_STEPS * (bze_pkg::W_U + 5) + 4;

    logic                           i_clk;
    logic                           i_rst_n;
    logic                           start;
    logic                           busy;
    logic [bze_pkg::W_T-1:0]        i_progress;
    logic                           o_valid;
    logic signed [bze_pkg::W_Y-1:0] o_eased;
    logic                           i_cfg_we;
    logic [1:0]                     i_cfg_idx;
    logic [bze_pkg::W_Y-1:0]        i_cfg_data;

    easing_scoreboard sb = new();
    bit burst;

    cubic_bezier_easing_unit DUT (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .start      (start),
        .busy       (busy),
        .i_progress (i_progress),
        .o_valid    (o_valid),
        .o_eased    (o_eased),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data)
    );

    always begin
        i_clk = 1'b0;
        #5;
        i_clk = 1'b1;
        #5;
    end

    // Sample both handshakes on the rising edge; inputs only move on the falling one.
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (start && !busy) sb.note_beat(i_progress);
            if (o_valid) sb.check_beat(o_eased);
        end
    end

    // Hold start high across back-to-back beats; drop it only for a gap.
    task automatic send_beat(logic [bze_pkg::W_T-1:0] prog);
        int gap;
        gap = burst ? 0 : $urandom_range(0, 11);
        repeat (gap) begin
            @(negedge i_clk);
            start = 1'b0;
        end
        @(negedge i_clk);
        start      = 1'b1;
        i_progress = prog;
        do @(posedge i_clk); while (busy);
    endtask

    // Drain the pipe so a register write never lands under a beat in flight.
    task automatic drain();
        @(negedge i_clk);
        start = 1'b0;
        while (sb.eased_q.size() != 0) @(posedge i_clk);
        repeat (LATENCY + 8) @(posedge i_clk);
    endtask

    task automatic write_reg(bze_pkg::t_cfg_idx idx, logic [bze_pkg::W_Y-1:0] data);
        @(negedge i_clk);
        i_cfg_we   = 1'b1;
        i_cfg_idx  = idx;
        i_cfg_data = data;
        sb.write_reg(idx, data);
        @(negedge i_clk);
        i_cfg_we = 1'b0;
    endtask

    task automatic load_curve(logic [bze_pkg::W_Y-1:0] px1, logic [bze_pkg::W_Y-1:0] py1,
                              logic [bze_pkg::W_Y-1:0] px2, logic [bze_pkg::W_Y-1:0] py2);
        drain();
        write_reg(bze_pkg::CFG_X1, px1);
        write_reg(bze_pkg::CFG_Y1, py1);
        write_reg(bze_pkg::CFG_X2, px2);
        write_reg(bze_pkg::CFG_Y2, py2);
    endtask

    function automatic logic [bze_pkg::W_Y-1:0] rand_x();
        // mostly legal 0..1.0, sometimes raw 19-bit patterns (upper bits dropped)
        if ($urandom_range(0, 4) == 0) return bze_pkg::W_Y'($urandom);
        return bze_pkg::W_Y'($urandom_range(0, bze_pkg::ONE));
    endfunction

    function automatic logic [bze_pkg::W_Y-1:0] rand_y();
        if ($urandom_range(0, 4) == 0) return bze_pkg::W_Y'($urandom);
        return bze_pkg::W_Y'(int'($urandom_range(0, bze_pkg::OUT_MAX - bze_pkg::OUT_MIN))
                             + bze_pkg::OUT_MIN);
    endfunction

    function automatic logic [bze_pkg::W_T-1:0] rand_progress();
        case ($urandom_range(0, 9))
            0: return bze_pkg::W_T'($urandom);
            1: return ($urandom_range(0, 1) != 0) ? bze_pkg::W_T'(0)
                                                  : bze_pkg::W_T'(bze_pkg::ONE);
            default: return bze_pkg::W_T'($urandom_range(0, bze_pkg::ONE));
        endcase
    endfunction

    task automatic random_run(int count);
        for (int n = 0; n < count; n++) begin
            // mix stretches of back-to-back beats with gappy ones
            if (n % 25 == 0) burst = ($urandom_range(0, 3) == 0);
            send_beat(rand_progress());
        end
    endtask

    initial begin
        logic [bze_pkg::W_T-1:0] edge_t[7];
        edge_t = '{bze_pkg::W_T'(0), bze_pkg::W_T'(1), bze_pkg::W_T'(32768),
                   bze_pkg::W_T'(65535), bze_pkg::W_T'(bze_pkg::ONE),
                   bze_pkg::W_T'(bze_pkg::ONE + 1), bze_pkg::W_T'(131071)};
        burst      = 1'b0;
        start      = 1'b0;
        i_progress = '0;
        i_cfg_we   = 1'b0;
        i_cfg_idx  = bze_pkg::CFG_X1;
        i_cfg_data = '0;
        i_rst_n    = 1'b0;
        repeat (12) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // default curve is the linear one
        foreach (edge_t[k]) send_beat(edge_t[k]);

        // flat spot at u = 0: both x control points at zero
        load_curve('0, bze_pkg::W_Y'(40000), '0, bze_pkg::W_Y'(-20000));
        foreach (edge_t[k]) send_beat(edge_t[k]);

        // extreme control points, both orientations
        load_curve('0, bze_pkg::W_Y'(bze_pkg::OUT_MIN), bze_pkg::W_Y'(bze_pkg::ONE),
                   bze_pkg::W_Y'(bze_pkg::OUT_MAX));
        foreach (edge_t[k]) send_beat(edge_t[k]);
        load_curve(bze_pkg::W_Y'(bze_pkg::ONE), bze_pkg::W_Y'(bze_pkg::OUT_MAX), '0,
                   bze_pkg::W_Y'(bze_pkg::OUT_MIN));
        random_run(100);

        // linear shortcut with equal x and y control points away from the default corners
        load_curve(bze_pkg::W_Y'(30000), bze_pkg::W_Y'(30000), bze_pkg::W_Y'(50000),
                   bze_pkg::W_Y'(50000));
        random_run(60);

        // a common ease-in-out shape
        load_curve(bze_pkg::W_Y'(27525), '0, bze_pkg::W_Y'(38011),
                   bze_pkg::W_Y'(bze_pkg::ONE));
        random_run(120);

        for (int p = 0; p < 8; p++) begin
            load_curve(rand_x(), rand_y(), rand_x(), rand_y());
            random_run(90);
        end

        // leave every register raw with all ones
        load_curve(bze_pkg::W_Y'(-1), bze_pkg::W_Y'(-1), bze_pkg::W_Y'(-1),
                   bze_pkg::W_Y'(-1));
        random_run(30);

        drain();
        if (sb.errors == 0 && sb.eased_q.size() == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

    initial begin
        #5_000_000;
        $display("Verification failed");
        $finish;
    end

endmodule

[filelist.f]
hdl/bze_pkg.sv
hdl/bze_div_cell.sv
hdl/bze_newton_cell.sv
hdl/cubic_bezier_easing_unit.sv
test/testbench.sv
